### rtl/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int PRI_W    = 8;
    localparam int TIME_W   = 16;
    localparam int RAN_W    = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [PRI_W-1:0] t_pri;

    // One job table entry as held in the RAM.
    typedef struct packed {
        t_pri  priority_level;
        t_time arrival;
        t_time burst;
        t_time remaining;
        t_time first_start;
    } t_job_rec;

    localparam int REC_W = $bits(t_job_rec);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_FETCH,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic scan;
        logic fetch;
        logic update;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_func;
        logic scan_done;
        logic slot_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

### rtl/pps_stream_if.sv
// Job input and result output channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

interface pps_job_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [pps_pkg::PRI_W-1:0]   priority_level;
    logic [pps_pkg::TIME_W-1:0]  arrival_time;
    logic [pps_pkg::TIME_W-1:0]  burst_length;

    modport source (output valid, func, priority_level, arrival_time, burst_length,
                    input ready);
    modport sink (input valid, func, priority_level, arrival_time, burst_length,
                  output ready);
endinterface

interface pps_res_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic                        ran_valid;
    logic [pps_pkg::RAN_W-1:0]   ran_index;
    logic                        switched;
    logic                        finished;
    logic [pps_pkg::TIME_W-1:0]  waiting_time;
    logic [pps_pkg::TIME_W-1:0]  turnaround_time;
    logic [pps_pkg::TIME_W-1:0]  response_time;
    logic [pps_pkg::TIME_W-1:0]  time_now;

    modport source (output valid, status, ran_valid, ran_index, switched, finished,
                    waiting_time, turnaround_time, response_time, time_now,
                    input ready);
    modport sink (input valid, status, ran_valid, ran_index, switched, finished,
                  waiting_time, turnaround_time, response_time, time_now,
                  output ready);
endinterface

`default_nettype wire

### rtl/pps_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/pps_ctrl.sv
// Sequencing state machine of the scheduler: load, scan, fetch and update steps.
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire pps_pkg::t_ctl_sts i_sts,
    output      pps_pkg::t_ctl_cmd o_cmd
);

    pps_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.in_func == pps_pkg::FUNC_TICK) ? pps_pkg::ST_SCAN
                                                                     : pps_pkg::ST_LOAD;
                end
            end
            pps_pkg::ST_LOAD: begin
                if (i_sts.slot_free) n_state = pps_pkg::ST_IDLE;
            end
            pps_pkg::ST_SCAN: begin
                if (i_sts.scan_done) n_state = pps_pkg::ST_FETCH;
            end
            pps_pkg::ST_FETCH: begin
                n_state = pps_pkg::ST_UPDATE;
            end
            pps_pkg::ST_UPDATE: begin
                if (i_sts.slot_free) n_state = pps_pkg::ST_IDLE;
            end
            default: n_state = pps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            pps_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            pps_pkg::ST_LOAD:   o_cmd.load   = i_sts.slot_free;
            pps_pkg::ST_SCAN:   o_cmd.scan   = 1'b1;
            pps_pkg::ST_FETCH:  o_cmd.fetch  = 1'b1;
            pps_pkg::ST_UPDATE: o_cmd.update = i_sts.slot_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/pps_datapath.sv
// Scheduler datapath: job table RAM, scan compare, time keeping, result register.
`timescale 1ns / 1ps
`default_nettype none

module pps_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_func,
    input  wire pps_pkg::t_pri     i_in_priority_level,
    input  wire pps_pkg::t_time    i_in_arrival_time,
    input  wire pps_pkg::t_time    i_in_burst_length,
    input  wire pps_pkg::t_ctl_cmd i_cmd,
    output      pps_pkg::t_ctl_sts o_sts,
    pps_res_if.source              o_res
);

    // Control state
    pps_pkg::t_cnt                  r_count;
    pps_pkg::t_time                 r_time;
    logic                           r_run_valid;
    pps_pkg::t_idx                  r_run_idx;
    logic [pps_pkg::MAX_JOBS-1:0]   r_done;
    logic [pps_pkg::MAX_JOBS-1:0]   r_started;
    pps_pkg::t_cnt                  r_scan_idx;
    logic                           r_cmp_vld;
    pps_pkg::t_cnt                  r_cmp_idx;
    logic                           r_found;
    logic                           r_run_elig;
    logic                           r_out_valid;

    // Payload registers
    pps_pkg::t_pri                  r_in_pri;
    pps_pkg::t_time                 r_in_arr;
    pps_pkg::t_time                 r_in_burst;
    pps_pkg::t_idx                  r_best_idx;
    pps_pkg::t_pri                  r_best_pri;
    pps_pkg::t_pri                  r_run_pri;
    pps_pkg::t_idx                  r_sel;
    logic                           r_status;
    logic                           r_ran_valid;
    logic [pps_pkg::RAN_W-1:0]      r_ran_index;
    logic                           r_switched;
    logic                           r_finished;
    pps_pkg::t_time                 r_wait;
    pps_pkg::t_time                 r_turn;
    pps_pkg::t_time                 r_resp;
    pps_pkg::t_time                 r_time_now;

    logic                           ram_we;
    pps_pkg::t_idx                  ram_waddr;
    pps_pkg::t_job_rec              ram_wdata;
    logic                           ram_re;
    pps_pkg::t_idx                  ram_raddr;
    pps_pkg::t_job_rec              ram_rdata;

    logic                           table_full;
    logic                           scan_more;
    pps_pkg::t_idx                  cmp_idx;
    pps_pkg::t_idx                  load_idx;
    logic                           cmp_elig;
    logic                           use_run;
    pps_pkg::t_idx                  sel;
    logic                           slot_free;
    pps_pkg::t_time                 time_next;
    pps_pkg::t_time                 rem_next;
    pps_pkg::t_time                 first_start;
    pps_pkg::t_time                 turn;
    pps_pkg::t_time                 resp;
    pps_pkg::t_time                 wait_t;
    logic                           fin;

    pps_ram #(
        .WIDTH (pps_pkg::REC_W),
        .DEPTH (pps_pkg::MAX_JOBS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign table_full = (r_count >= pps_pkg::CNT_W'(pps_pkg::MAX_JOBS));
    assign scan_more  = (r_scan_idx < r_count);
    assign cmp_idx    = r_cmp_idx[pps_pkg::IDX_W-1:0];
    assign load_idx   = r_count[pps_pkg::IDX_W-1:0];
    assign cmp_elig   = !r_done[cmp_idx] && (ram_rdata.arrival <= r_time);

    // On a priority tie the job that ran last tick keeps the slot.
    assign use_run = r_found && r_run_valid && r_run_elig && (r_run_pri == r_best_pri);
    assign sel     = use_run ? r_run_idx : r_best_idx;

    assign slot_free = !r_out_valid || o_res.ready;

    assign time_next   = (r_time == pps_pkg::TIME_MAX) ? r_time : r_time + 1'b1;
    assign rem_next    = ram_rdata.remaining - 1'b1;
    assign fin         = (rem_next == '0);
    assign first_start = r_started[r_sel] ? ram_rdata.first_start : r_time;
    assign turn        = time_next - ram_rdata.arrival;
    assign resp        = first_start - ram_rdata.arrival;
    assign wait_t      = (turn >= ram_rdata.burst) ? turn - ram_rdata.burst : '0;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = load_idx;
        ram_wdata = ram_rdata;
        if (i_cmd.load) begin
            ram_we                   = !table_full;
            ram_wdata.priority_level = r_in_pri;
            ram_wdata.arrival        = r_in_arr;
            ram_wdata.burst          = r_in_burst;
            ram_wdata.remaining      = r_in_burst;
            ram_wdata.first_start    = '0;
        end else if (i_cmd.update) begin
            ram_we                = r_found;
            ram_waddr             = r_sel;
            ram_wdata.remaining   = rem_next;
            ram_wdata.first_start = first_start;
        end
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_scan_idx[pps_pkg::IDX_W-1:0];
        if (i_cmd.scan) begin
            ram_re = scan_more;
        end else if (i_cmd.fetch) begin
            ram_re    = r_found;
            ram_raddr = sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_time      <= '0;
            r_run_valid <= 1'b0;
            r_run_idx   <= '0;
            r_done      <= '0;
            r_started   <= '0;
            r_scan_idx  <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_idx   <= '0;
            r_found     <= 1'b0;
            r_run_elig  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
                r_found    <= 1'b0;
                r_run_elig <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_cmp_vld <= scan_more;
                r_cmp_idx <= r_scan_idx;
                if (scan_more) r_scan_idx <= r_scan_idx + 1'b1;
                if (r_cmp_vld) begin
                    if (cmp_elig) r_found <= 1'b1;
                    if (cmp_idx == r_run_idx) r_run_elig <= cmp_elig;
                end
            end
            if (i_cmd.load && !table_full) begin
                r_count            <= r_count + 1'b1;
                r_done[load_idx]    <= (r_in_burst == '0);
                r_started[load_idx] <= 1'b0;
            end
            if (i_cmd.update) begin
                r_time      <= time_next;
                r_run_valid <= r_found;
                if (r_found) begin
                    r_run_idx        <= r_sel;
                    r_started[r_sel] <= 1'b1;
                    r_done[r_sel]    <= fin;
                end
            end
            if (i_cmd.load || i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_pri   <= i_in_priority_level;
            r_in_arr   <= i_in_arrival_time;
            r_in_burst <= i_in_burst_length;
        end
        if (i_cmd.scan && r_cmp_vld) begin
            if (cmp_elig && (!r_found || ram_rdata.priority_level < r_best_pri)) begin
                r_best_idx <= cmp_idx;
                r_best_pri <= ram_rdata.priority_level;
            end
            if (cmp_idx == r_run_idx) r_run_pri <= ram_rdata.priority_level;
        end
        if (i_cmd.fetch) begin
            r_sel <= sel;
        end
        if (i_cmd.load) begin
            r_status    <= table_full ? pps_pkg::STATUS_FULL : pps_pkg::STATUS_OK;
            r_ran_valid <= 1'b0;
            r_ran_index <= '0;
            r_switched  <= 1'b0;
            r_finished  <= 1'b0;
            r_wait      <= '0;
            r_turn      <= '0;
            r_resp      <= '0;
            r_time_now  <= r_time;
        end else if (i_cmd.update) begin
            r_status    <= pps_pkg::STATUS_OK;
            r_ran_valid <= r_found;
            r_ran_index <= r_found ? pps_pkg::RAN_W'(r_sel) : '0;
            r_switched  <= r_found && (!r_run_valid || (r_run_idx != r_sel));
            r_finished  <= r_found && fin;
            r_wait      <= (r_found && fin) ? wait_t : '0;
            r_turn      <= (r_found && fin) ? turn : '0;
            r_resp      <= (r_found && fin) ? resp : '0;
            r_time_now  <= time_next;
        end
    end

    assign o_sts.in_func   = i_in_func;
    assign o_sts.scan_done = !scan_more && !r_cmp_vld;
    assign o_sts.slot_free = slot_free;

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_status;
    assign o_res.ran_valid       = r_ran_valid;
    assign o_res.ran_index       = r_ran_index;
    assign o_res.switched        = r_switched;
    assign o_res.finished        = r_finished;
    assign o_res.waiting_time    = r_wait;
    assign o_res.turnaround_time = r_turn;
    assign o_res.response_time   = r_resp;
    assign o_res.time_now        = r_time_now;

endmodule

`default_nettype wire

### rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler.
//
// Each input transfer either loads one job into a 16-entry table (func 0) or
// advances time by one tick (func 1), and gives exactly one result transfer.
// A load writes its entry and the result register once the output register is
// free. A tick scans the table through the single read port of the job RAM, one
// entry a cycle, then reads the chosen entry back and updates it, again once the
// output register is free. Only one item is in work at a time, but the next one
// is accepted while the previous result still waits in the output register.
// Smaller priority numbers win; on a tie the job that ran last tick keeps
// running, otherwise the lowest index.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pps_job_if.sink    i_job,
    pps_res_if.source  o_res
);

    pps_pkg::t_ctl_cmd cmd;
    pps_pkg::t_ctl_sts sts;
    logic              in_ready;

    assign i_job.ready = in_ready;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_job.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pps_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_func           (i_job.func),
        .i_in_priority_level (i_job.priority_level),
        .i_in_arrival_time   (i_job.arrival_time),
        .i_in_burst_length   (i_job.burst_length),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_res               (o_res)
    );

endmodule

`default_nettype wire
